/* design/xtea_pkg.sv */
// Shared types, constants and helpers for the XTEA pipelined cipher.
// Used by xtea_round, xtea_out_buf and xtea_block_cipher_top.
package xtea_pkg;

  localparam int unsigned CYCLES = 32;
  localparam int unsigned STAGES = 2 * CYCLES;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned KIDX_W = 2;

  localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

  // Command codes carried in tuser
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

  // One item as it travels through the rounds
  typedef struct packed {
    logic  cmd;
    word_t v1;
    word_t v0;
  } stage_data_t;

  // Per-stage constants: half-round parity and the running sums
  typedef struct packed {
    logic  odd;
    word_t enc_sum;
    word_t dec_sum;
  } stage_const_t;

  // delta * n modulo 2^32
  function automatic word_t delta_times(input int unsigned n);
    logic [63:0] prod;
    begin
      prod = 64'(DELTA) * 64'(n);
      return prod[WORD_W-1:0];
    end
  endfunction

  // Constants of half-round k (0 .. STAGES-1)
  function automatic stage_const_t stage_const(input int unsigned k);
    stage_const_t c;
    int unsigned  n;
    begin
      n = k / 2;
      c.odd = (k % 2) == 1;
      if (c.odd) begin
        c.enc_sum = delta_times(n + 1);
        c.dec_sum = delta_times(CYCLES - n - 1);
      end else begin
        c.enc_sum = delta_times(n);
        c.dec_sum = delta_times(CYCLES - n);
      end
      return c;
    end
  endfunction

  // ((v << 4) ^ (v >> 5)) + v
  function automatic word_t mix_word(input word_t v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

/* design/xtea_block_cipher_top.sv */
// XTEA cipher top: key registers, 64 half-round stages and output buffer.
// Depends on xtea_pkg, xtea_round and xtea_out_buf.
//
// Usage:
//   Input channel in_*: one item is one 64-bit block (tdata) plus a command
//   in tuser (0 encrypt, 1 decrypt). Result channel out_*: the processed
//   block in the same word layout.
//   Key: four 32-bit words written through cfg_we/cfg_index/cfg_wdata.
//   Write the key only while no item is in flight.
//   Throughput: one item per cycle while the skid register is empty. Each of the
//   32 rounds (CYCLES) of the cipher is unrolled into two stages (one half-round each);
//   an accepted item passes through 64 half-round registers, the first loaded
//   at the accepting edge, then through the output register to out_tvalid.
//   Stall: when the receiver holds out_tready low, the next finished item
//   lands in a skid register and the pipeline then freezes; in_tready drops
//   for as long as the skid register is occupied. Nothing is dropped.
//   Reset (rst_n low, synchronous): pipeline and output valid bits clear,
//   key words return to zero.
module xtea_block_cipher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // in_first[31:0], in_second[63:32]
  input  logic [0:0]  in_tuser,   // cmd[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // out_first[31:0], out_second[63:32]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  xtea_pkg::key_t         key_r;
  logic                   adv;
  logic                   stg_valid [xtea_pkg::STAGES+1];
  xtea_pkg::stage_data_t  stg_data  [xtea_pkg::STAGES+1];

  // Key word registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      key_r[cfg_index] <= cfg_wdata;
    end
  end

  // Pipeline entry
  assign in_tready        = adv;
  assign stg_valid[0]     = in_tvalid;
  assign stg_data[0].cmd  = in_tuser[0];
  assign stg_data[0].v0   = in_tdata[31:0];
  assign stg_data[0].v1   = in_tdata[63:32];

  // Unrolled half-rounds
  for (genvar k = 0; k < xtea_pkg::STAGES; k++) begin : g_round
    xtea_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (stg_valid[k]),
      .in_data   (stg_data[k]),
      .consts    (xtea_pkg::stage_const(k)),
      .key       (key_r),
      .out_valid (stg_valid[k+1]),
      .out_data  (stg_data[k+1])
    );
  end

  // Output register and skid
  xtea_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .p_valid    (stg_valid[xtea_pkg::STAGES]),
    .p_data     (stg_data[xtea_pkg::STAGES]),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* design/xtea_round.sv */
// One XTEA half-round pipeline stage, encrypt or decrypt per item.
// Depends on xtea_pkg for types and the mix function.
module xtea_round (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,        // pipeline advance
  input  logic                     in_valid,
  input  xtea_pkg::stage_data_t    in_data,
  input  xtea_pkg::stage_const_t   consts,
  input  xtea_pkg::key_t           key,
  output logic                     out_valid,
  output xtea_pkg::stage_data_t    out_data
);

  logic                        valid_r;
  xtea_pkg::stage_data_t       data_r;
  xtea_pkg::stage_data_t       data_nxt;

  logic                        upd_first;
  xtea_pkg::word_t             src;
  xtea_pkg::word_t             tgt;
  xtea_pkg::word_t             sum;
  logic [xtea_pkg::KIDX_W-1:0] kidx;
  xtea_pkg::word_t             f;
  xtea_pkg::word_t             res;

  // Which word this half-round updates: encrypt even/decrypt odd touch v0
  always_comb begin
    upd_first = (in_data.cmd == xtea_pkg::CMD_DECRYPT) ? consts.odd : ~consts.odd;
    src  = upd_first ? in_data.v1 : in_data.v0;
    tgt  = upd_first ? in_data.v0 : in_data.v1;
    sum  = (in_data.cmd == xtea_pkg::CMD_DECRYPT) ? consts.dec_sum : consts.enc_sum;
    kidx = upd_first ? sum[1:0] : sum[12:11];
    f    = xtea_pkg::mix_word(src) ^ (sum + key[kidx]);
    res  = (in_data.cmd == xtea_pkg::CMD_DECRYPT) ? (tgt - f) : (tgt + f);
    data_nxt     = in_data;
    if (upd_first) begin
      data_nxt.v0 = res;
    end else begin
      data_nxt.v1 = res;
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* design/xtea_out_buf.sv */
// Output register plus skid stage behind the round pipeline.
// Depends on xtea_pkg for word types.
module xtea_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   p_valid,     // last pipeline stage
  input  xtea_pkg::stage_data_t  p_data,
  output logic                   adv,         // pipeline may shift
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [63:0]            out_tdata    // out_first[31:0], out_second[63:32]
);

  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic        skid_valid_r;
  logic [63:0] skid_data_r;
  logic        push;
  logic        out_free;

  // Pipeline stops only while the skid stage holds an item
  assign adv      = ~skid_valid_r;
  assign push     = adv & p_valid;
  assign out_free = ~out_valid_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (out_tready) begin
          skid_valid_r <= 1'b0;
        end
      end else if (push && !out_free) begin
        skid_valid_r <= 1'b1;
      end
      if (out_free) begin
        out_valid_r <= skid_valid_r | push;
      end
    end
  end

  // Payload: skid item goes first, otherwise the fresh pipeline item
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : {p_data.v1, p_data.v0};
    end
    if (push && !out_free) begin
      skid_data_r <= {p_data.v1, p_data.v0};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* bench/xtea_block_cipher_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for xtea_block_cipher_top: mirrors the key registers, predicts
// every accepted block and compares it with the result stream in order.
// Depends on xtea_pkg for word types, command codes and the round constants.
module xtea_block_cipher_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // in_first[31:0], in_second[63:32]
  input  logic [0:0]  in_tuser,   // cmd[0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,  // out_first[31:0], out_second[63:32]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          pending,
  output int          errors
);

  typedef struct packed {
    xtea_pkg::word_t second;
    xtea_pkg::word_t first;
  } cipher_block_t;

  xtea_pkg::word_t key_words [xtea_pkg::KEY_WORDS];
  cipher_block_t   expected_blocks [$];

  // Feistel mixing: shifted copies xor'ed, then the word added back
  function automatic xtea_pkg::word_t feistel_f(input xtea_pkg::word_t v);
    return ({v[27:0], 4'b0000} ^ {5'b00000, v[31:5]}) + v;
  endfunction

  // Full XTEA transform under the mirrored key
  function automatic cipher_block_t xtea_cipher_block(input logic op,
                                                      input xtea_pkg::word_t a,
                                                      input xtea_pkg::word_t b);
    cipher_block_t   blk;
    xtea_pkg::word_t sum;
    if (op == xtea_pkg::CMD_DECRYPT) begin
      sum = xtea_pkg::word_t'(xtea_pkg::DELTA * xtea_pkg::CYCLES);
      for (int n = 0; n < xtea_pkg::CYCLES; n++) begin
        b -= feistel_f(a) ^ (sum + key_words[sum[12:11]]);
        sum -= xtea_pkg::DELTA;
        a -= feistel_f(b) ^ (sum + key_words[sum[1:0]]);
      end
    end else begin
      sum = '0;
      for (int n = 0; n < xtea_pkg::CYCLES; n++) begin
        a += feistel_f(b) ^ (sum + key_words[sum[1:0]]);
        sum += xtea_pkg::DELTA;
        b += feistel_f(a) ^ (sum + key_words[sum[12:11]]);
      end
    end
    blk.first = a;
    blk.second = b;
    return blk;
  endfunction

  // Predict on input accept, compare on output accept, track key writes
  always @(posedge clk) begin
    cipher_block_t want;
    if (!rst_n) begin
      key_words = '{default: '0};
      expected_blocks.delete();
    end else begin
      if (in_tvalid && in_tready)
        expected_blocks.insert(expected_blocks.size(),
                               xtea_cipher_block(in_tuser[0], in_tdata[31:0],
                                                 in_tdata[63:32]));
      if (out_tvalid && out_tready) begin
        if (expected_blocks.size() == 0) begin
          $error("unexpected item: out_first %08h, out_second %08h",
                 out_tdata[31:0], out_tdata[63:32]);
          errors++;
        end else begin
          want = expected_blocks.pop_front();
          if (out_tdata[31:0] !== want.first) begin
            $error("out_first mismatch: expected %08h, got %08h",
                   want.first, out_tdata[31:0]);
            errors++;
          end
          if (out_tdata[63:32] !== want.second) begin
            $error("out_second mismatch: expected %08h, got %08h",
                   want.second, out_tdata[63:32]);
            errors++;
          end
        end
      end
      // a key write takes effect for items accepted after this edge
      if (cfg_we)
        key_words[cfg_index] = cfg_wdata;
    end
    pending <= expected_blocks.size();
  end

endmodule

/* bench/xtea_block_cipher_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top for xtea_block_cipher_top: clock, reset, key loads, block
// stimulus with random gaps and receiver stalls, watchdog and verdict.
// Depends on xtea_pkg, the block itself and xtea_block_cipher_checker.
module xtea_block_cipher_top_tb;

  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned RANDOM_PHASES   = 6;
  localparam int unsigned ITEMS_PER_PHASE = 190;
  localparam int unsigned TAIL_CYCLES     = 70;

  localparam logic [1:0] KEY_WORD0 = 2'd0;
  localparam logic [1:0] KEY_WORD1 = 2'd1;
  localparam logic [1:0] KEY_WORD2 = 2'd2;
  localparam logic [1:0] KEY_WORD3 = 2'd3;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;   // in_first[31:0], in_second[63:32]
  logic [0:0]  in_tuser   = '0;   // cmd[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;         // out_first[31:0], out_second[63:32]
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [31:0] cfg_wdata  = '0;

  int          pending;
  int          errors;
  bit          tx_steady;
  bit          rx_steady;
  int unsigned stall_left;

  xtea_block_cipher_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  xtea_block_cipher_checker u_scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .errors     (errors)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(20, 120);
    return $urandom_range(1, 3);
  endfunction

  // Random word with a bias toward all-zero, all-one and one-hot values
  function automatic xtea_pkg::word_t pick_word();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      2: return xtea_pkg::word_t'(1) << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  // Receiver: random stalls unless in a steady stretch
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (!rx_steady && $urandom_range(0, 4) == 0)
        stall_left <= pick_gap();
    end
  end

  // Offer one block and hold it until accepted, then maybe idle
  task automatic send_block(input logic op, input xtea_pkg::word_t first,
                            input xtea_pkg::word_t second);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {second, first};
    do @(posedge clk); while (!in_tready);
    gap = (!tx_steady && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every predicted block has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_key_word(input logic [1:0] idx, input xtea_pkg::word_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Only called while the pipeline is empty
  task automatic load_key(input xtea_pkg::word_t k0, input xtea_pkg::word_t k1,
                          input xtea_pkg::word_t k2, input xtea_pkg::word_t k3);
    set_key_word(KEY_WORD0, k0);
    set_key_word(KEY_WORD1, k1);
    set_key_word(KEY_WORD2, k2);
    set_key_word(KEY_WORD3, k3);
    cfg_we <= 1'b0;
  endtask

  // Watchdog: too long without any accepted item ends the run
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("xtea_block_cipher_top_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    xtea_pkg::word_t corner_first [6];
    xtea_pkg::word_t corner_second [6];
    corner_first  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                      32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001};
    corner_second = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'h0000_0000, 32'h0000_0001, 32'h8000_0000};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corner blocks under the all-zero reset key, both directions
    for (int i = 0; i < 6; i++) begin
      send_block(xtea_pkg::CMD_ENCRYPT, corner_first[i], corner_second[i]);
      send_block(xtea_pkg::CMD_DECRYPT, corner_first[i], corner_second[i]);
    end
    drain();

    // All-ones key
    load_key('1, '1, '1, '1);
    send_block(xtea_pkg::CMD_ENCRYPT, '0, '0);
    send_block(xtea_pkg::CMD_DECRYPT, '0, '0);
    send_block(xtea_pkg::CMD_ENCRYPT, '1, '1);
    send_block(xtea_pkg::CMD_DECRYPT, '1, '1);
    drain();

    // Distinct words so a wrong key index shows up
    load_key(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F);
    send_block(xtea_pkg::CMD_ENCRYPT, 32'h4142_4344, 32'h4546_4748);
    send_block(xtea_pkg::CMD_DECRYPT, 32'h4142_4344, 32'h4546_4748);
    send_block(xtea_pkg::CMD_ENCRYPT, '0, '1);
    send_block(xtea_pkg::CMD_DECRYPT, '1, '0);

    // Random phases, each loading its own key and setting the handshake pattern
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      case (phase)
        1: load_key('0, '1, '0, '1);
        3: load_key('0, '0, '0, '0);
        default: load_key(pick_word(), pick_word(), pick_word(), pick_word());
      endcase
      tx_steady = (phase == 2);
      rx_steady = (phase == 2) || (phase == 4);
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_block(logic'($urandom_range(0, 1)), pick_word(), pick_word());
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("xtea_block_cipher_top_tb OK");
    else
      $display("xtea_block_cipher_top_tb NOT OK");
    $finish;
  end

endmodule
